// File: hdl/ccd_corner_difference_unit_top_macros.svh
// Assertion macros shared by the corner difference unit checker.
`ifndef CCD_CORNER_DIFFERENCE_UNIT_TOP_MACROS_SVH
`define CCD_CORNER_DIFFERENCE_UNIT_TOP_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define CCD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define CCD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/ccd_pkg.sv
// Package with widths, latencies and stage types of the corner difference unit.
package ccd_pkg;

   localparam int COORD_BITS = 48;
   localparam int PARAM_BITS = 32;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int PROD_W     = DIFF_W + PARAM_BITS;
   localparam int MUL_LO_W   = 32;
   localparam int MUL_HI_W   = DIFF_W - MUL_LO_W;
   localparam int ACC_W      = DIFF_W + 1;
   localparam int RES_W      = DIFF_W + 2;
   localparam int SCALE_LAT  = DIFF_W + 4;
   localparam int NUM_REGS   = 8;
   localparam int NUM_PTS    = 4;
   localparam int REG_IDX_W  = 3;
   localparam int CSR_IDX_W  = 4;
   localparam int REQ_DATA_W = 6 * PARAM_BITS;
   localparam int RSP_DATA_W = ((DIFF_W + 7) / 8) * 8;

   localparam logic OP_EDGE_EDGE   = 1'b0;
   localparam logic OP_VERTEX_FACE = 1'b1;

   typedef struct packed {
      logic                         op;
      logic                         err;
      logic [PARAM_BITS-1:0]        un;
      logic [PARAM_BITS-1:0]        ud;
      logic [PARAM_BITS-1:0]        vn;
      logic [PARAM_BITS-1:0]        vd;
      logic signed [COORD_BITS-1:0] s0;
      logic signed [COORD_BITS-1:0] s1;
      logic signed [COORD_BITS-1:0] s2;
      logic signed [COORD_BITS-1:0] s3;
   } time_side_type;

   typedef struct packed {
      logic                         op;
      logic                         err;
      logic signed [COORD_BITS-1:0] p0;
      logic signed [COORD_BITS-1:0] p1;
      logic signed [COORD_BITS-1:0] p2;
   } uv_side_type;

endpackage

// File: hdl/ccd_corner_difference_unit_top.sv
// Top level of the corner difference unit: configuration, pipeline and result stage.
//
//   channel | direction | carries
//   req_    | in        | one corner request: opcode and three num/den parameters
//   rsp_    | out       | one result: difference and parameter error flag
//   csr_    | in        | point start/end positions, index 0..7
//
// Every request passes the capture stage, the time scale units, the position and
// difference stages, the u and v scale units, the final difference stage and the result
// register; each scale unit is a long division that retires one quotient bit per stage.
// A new request is accepted in every cycle while the result side keeps up.
// Reset is synchronous and active high; it clears all valid bits and the configuration registers.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
module ccd_corner_difference_unit_top
   import ccd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // time_num, time_den, first_num, first_den, second_num, second_den (low to high)
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // difference, then zero padding
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // param_error
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COORD_BITS-1:0] csr_data
);

   localparam logic signed [RES_W-1:0] OUT_HIGH = RES_W'((65'sd1 <<< COORD_BITS) - 1);
   localparam logic signed [RES_W-1:0] OUT_LOW  = -OUT_HIGH - RES_W'(1);

   logic adv;

   logic signed [COORD_BITS-1:0] cfg_ff [0:NUM_REGS-1];

   // Stage 0: captured request, time differences of the four points.
   logic                     v0_ff;
   logic [PARAM_BITS-1:0]    tn0_ff, td0_ff;
   time_side_type            side0_ff;
   logic signed [DIFF_W-1:0] dt0_ff [0:NUM_PTS-1];
   logic signed [DIFF_W-1:0] qt [0:NUM_PTS-1];

   time_side_type dla_ff [0:SCALE_LAT-1];
   logic          vla_ff [0:SCALE_LAT-1];

   // Stage 1: positions at time t.
   logic                         v1_ff;
   time_side_type                side1_ff;
   logic signed [COORD_BITS-1:0] p1_ff [0:NUM_PTS-1];

   // Stage 2: differences fed to the u and v scale units.
   logic                     v2_ff;
   logic signed [DIFF_W-1:0] da2_ff, db2_ff;
   logic [PARAM_BITS-1:0]    un2_ff, ud2_ff, vn2_ff, vd2_ff;
   uv_side_type              side2_ff;
   logic signed [DIFF_W-1:0] qa, qb;

   uv_side_type dlb_ff [0:SCALE_LAT-1];
   logic        vlb_ff [0:SCALE_LAT-1];

   // Stage 3: minuend and subtrahend of the final difference.
   logic                    v3_ff, err3_ff;
   logic signed [ACC_W-1:0] x3_ff, y3_ff;
   uv_side_type             tail;

   // Stage 4: result register.
   logic                    v4_ff, err4_ff;
   logic signed [DIFF_W-1:0] res4_ff;
   logic signed [RES_W-1:0] full;

   logic [PARAM_BITS-1:0] tn, td, un, ud, vn, vd;
   logic                  req_err;

   // The pipeline moves as one; the result register parts it from the consumer.
   assign adv        = !v4_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ff[i] <= '0;
         end
      end else if (csr_valid && (csr_index < CSR_IDX_W'(NUM_REGS))) begin
         cfg_ff[csr_index[REG_IDX_W-1:0]] <= csr_data;
      end
   end

   assign tn = req_tdata[0*PARAM_BITS +: PARAM_BITS];
   assign td = req_tdata[1*PARAM_BITS +: PARAM_BITS];
   assign un = req_tdata[2*PARAM_BITS +: PARAM_BITS];
   assign ud = req_tdata[3*PARAM_BITS +: PARAM_BITS];
   assign vn = req_tdata[4*PARAM_BITS +: PARAM_BITS];
   assign vd = req_tdata[5*PARAM_BITS +: PARAM_BITS];

   // A zero denominator or a numerator above its denominator is an error.
   assign req_err = (td == '0) || (ud == '0) || (vd == '0) ||
                    (tn > td) || (un > ud) || (vn > vd);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_tvalid;
      end
   end

   // The user must change configuration only while idle; the block does not enforce it, so it is read directly here.
   always_ff @(posedge clock) begin
      if (adv) begin
         tn0_ff       <= tn;
         td0_ff       <= td;
         side0_ff.op  <= req_tuser;
         side0_ff.err <= req_err;
         side0_ff.un  <= un;
         side0_ff.ud  <= ud;
         side0_ff.vn  <= vn;
         side0_ff.vd  <= vd;
         side0_ff.s0  <= cfg_ff[0];
         side0_ff.s1  <= cfg_ff[1];
         side0_ff.s2  <= cfg_ff[2];
         side0_ff.s3  <= cfg_ff[3];
         for (int i = 0; i < NUM_PTS; i++) begin
            dt0_ff[i] <= DIFF_W'(cfg_ff[i+NUM_PTS]) - DIFF_W'(cfg_ff[i]);
         end
      end
   end

   for (genvar i = 0; i < NUM_PTS; i++) begin : g_time
      ccd_scale u_scale (
         .clock (clock),
         .en    (adv),
         .diff  (dt0_ff[i]),
         .num   (tn0_ff),
         .den   (td0_ff),
         .quot  (qt[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SCALE_LAT; k++) begin
            vla_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vla_ff[0] <= v0_ff;
         for (int k = 1; k < SCALE_LAT; k++) begin
            vla_ff[k] <= vla_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dla_ff[0] <= side0_ff;
         for (int k = 1; k < SCALE_LAT; k++) begin
            dla_ff[k] <= dla_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= vla_ff[SCALE_LAT-1];
      end
   end

   // Each position lies between its start and end, so it fits the coordinate width.
   always_ff @(posedge clock) begin
      if (adv) begin
         side1_ff <= dla_ff[SCALE_LAT-1];
         p1_ff[0] <= COORD_BITS'(DIFF_W'(dla_ff[SCALE_LAT-1].s0) + qt[0]);
         p1_ff[1] <= COORD_BITS'(DIFF_W'(dla_ff[SCALE_LAT-1].s1) + qt[1]);
         p1_ff[2] <= COORD_BITS'(DIFF_W'(dla_ff[SCALE_LAT-1].s2) + qt[2]);
         p1_ff[3] <= COORD_BITS'(DIFF_W'(dla_ff[SCALE_LAT-1].s3) + qt[3]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   // Edge-edge scales both edges; vertex-face scales the two triangle sides from T0.
   always_ff @(posedge clock) begin
      if (adv) begin
         if (side1_ff.op == OP_VERTEX_FACE) begin
            da2_ff <= DIFF_W'(p1_ff[2]) - DIFF_W'(p1_ff[1]);
            db2_ff <= DIFF_W'(p1_ff[3]) - DIFF_W'(p1_ff[1]);
         end else begin
            da2_ff <= DIFF_W'(p1_ff[1]) - DIFF_W'(p1_ff[0]);
            db2_ff <= DIFF_W'(p1_ff[3]) - DIFF_W'(p1_ff[2]);
         end
         un2_ff       <= side1_ff.un;
         ud2_ff       <= side1_ff.ud;
         vn2_ff       <= side1_ff.vn;
         vd2_ff       <= side1_ff.vd;
         side2_ff.op  <= side1_ff.op;
         side2_ff.err <= side1_ff.err;
         side2_ff.p0  <= p1_ff[0];
         side2_ff.p1  <= p1_ff[1];
         side2_ff.p2  <= p1_ff[2];
      end
   end

   ccd_scale u_scale_u (
      .clock (clock),
      .en    (adv),
      .diff  (da2_ff),
      .num   (un2_ff),
      .den   (ud2_ff),
      .quot  (qa)
   );

   ccd_scale u_scale_v (
      .clock (clock),
      .en    (adv),
      .diff  (db2_ff),
      .num   (vn2_ff),
      .den   (vd2_ff),
      .quot  (qb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SCALE_LAT; k++) begin
            vlb_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vlb_ff[0] <= v2_ff;
         for (int k = 1; k < SCALE_LAT; k++) begin
            vlb_ff[k] <= vlb_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dlb_ff[0] <= side2_ff;
         for (int k = 1; k < SCALE_LAT; k++) begin
            dlb_ff[k] <= dlb_ff[k-1];
         end
      end
   end

   assign tail = dlb_ff[SCALE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= vlb_ff[SCALE_LAT-1];
      end
   end

   // Edge-edge: (p0 + qa) - (p2 + qb). Vertex-face: (p0 - p1) - (qa + qb).
   always_ff @(posedge clock) begin
      if (adv) begin
         err3_ff <= tail.err;
         if (tail.op == OP_VERTEX_FACE) begin
            x3_ff <= ACC_W'(tail.p0) - ACC_W'(tail.p1);
            y3_ff <= ACC_W'(qa) + ACC_W'(qb);
         end else begin
            x3_ff <= ACC_W'(tail.p0) + ACC_W'(qa);
            y3_ff <= ACC_W'(tail.p2) + ACC_W'(qb);
         end
      end
   end

   assign full = RES_W'(x3_ff) - RES_W'(y3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   // An error result is zero; else only vertex-face can leave the range, and it saturates to the nearest bound.
   always_ff @(posedge clock) begin
      if (adv) begin
         err4_ff <= err3_ff;
         if (err3_ff) begin
            res4_ff <= '0;
         end else if (full > OUT_HIGH) begin
            res4_ff <= DIFF_W'(OUT_HIGH);
         end else if (full < OUT_LOW) begin
            res4_ff <= DIFF_W'(OUT_LOW);
         end else begin
            res4_ff <= DIFF_W'(full);
         end
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = RSP_DATA_W'($unsigned(res4_ff));
   assign rsp_tuser  = err4_ff;

endmodule

// File: hdl/ccd_scale.sv
// Pipelined truncating scale unit: trunc(diff * num / den), one quotient bit per stage.
module ccd_scale
   import ccd_pkg::*;
(
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [DIFF_W-1:0] diff,
   input  logic [PARAM_BITS-1:0]    num,
   input  logic [PARAM_BITS-1:0]    den,
   output logic signed [DIFF_W-1:0] quot
);

   logic [DIFF_W-1:0]              mag0_ff;
   logic                           neg0_ff;
   logic [PARAM_BITS-1:0]          num0_ff;
   logic [PARAM_BITS-1:0]          den0_ff;
   logic [MUL_LO_W+PARAM_BITS-1:0] pplo1_ff;
   logic [MUL_HI_W+PARAM_BITS-1:0] pphi1_ff;
   logic                           neg1_ff;
   logic [PARAM_BITS-1:0]          den1_ff;
   logic [PROD_W-1:0]              prod;
   logic [PARAM_BITS-1:0]          rem_ff [0:DIFF_W-1];
   logic [PARAM_BITS-1:0]          den_ff [0:DIFF_W-1];
   logic [DIFF_W-1:0]              w_ff   [0:DIFF_W];
   logic                           neg_ff [0:DIFF_W];
   logic signed [DIFF_W-1:0]       quot_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         neg0_ff  <= diff[DIFF_W-1];
         mag0_ff  <= diff[DIFF_W-1] ? (-diff) : diff;
         num0_ff  <= num;
         den0_ff  <= den;
         pplo1_ff <= mag0_ff[MUL_LO_W-1:0] * num0_ff;
         pphi1_ff <= mag0_ff[DIFF_W-1:MUL_LO_W] * num0_ff;
         neg1_ff  <= neg0_ff;
         den1_ff  <= den0_ff;
      end
   end

   assign prod = PROD_W'(pplo1_ff) + (PROD_W'(pphi1_ff) << MUL_LO_W);

   // The high part of the product is below den whenever the parameter is valid.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= prod[PROD_W-1 -: PARAM_BITS];
         w_ff[0]   <= prod[DIFF_W-1:0];
         den_ff[0] <= den1_ff;
         neg_ff[0] <= neg1_ff;
      end
   end

   for (genvar k = 0; k < DIFF_W; k++) begin : g_step
      logic [PARAM_BITS:0] trial;
      logic                take;
      always_comb begin
         trial = {rem_ff[k], w_ff[k][DIFF_W-1]};
         take  = (trial >= {1'b0, den_ff[k]});
      end
      always_ff @(posedge clock) begin
         if (en) begin
            w_ff[k+1]   <= {w_ff[k][DIFF_W-2:0], take};
            neg_ff[k+1] <= neg_ff[k];
         end
      end
      if (k + 1 < DIFF_W) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1] <= take ? PARAM_BITS'(trial - {1'b0, den_ff[k]})
                                   : trial[PARAM_BITS-1:0];
               den_ff[k+1] <= den_ff[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= neg_ff[DIFF_W] ? (-$signed(w_ff[DIFF_W])) : $signed(w_ff[DIFF_W]);
      end
   end

   assign quot = quot_ff;

endmodule

// File: hdl/ccd_checker.sv
// Port-level checker of the corner difference unit, bound to the top level.
`include "ccd_corner_difference_unit_top_macros.svh"

module ccd_checker
   import ccd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   `CCD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   `CCD_ASSERT_IMP(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "error result is not zero")

   `CCD_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "result valid right after reset")

   `CCD_ASSERT_IMP(a_ready_free, clock, reset, !rsp_tvalid, req_tready, "request refused with empty result stage")

endmodule

bind ccd_corner_difference_unit_top ccd_checker u_ccd_checker (.*);
